>>> rtl/core/idru_pkg.sv
// Shared constants and pipeline payload type for the integer divide unit.
`default_nettype none

package idru_pkg;

    localparam int WORD_W = 32;

    // Payload carried from cell to cell down the divide chain.
    // part: partial remainder, below den between steps whenever den is nonzero.
    // nq:   dividend bits shift out the top while quotient bits shift in at the bottom.
    typedef struct packed {
        logic [WORD_W-1:0] part;
        logic [WORD_W-1:0] nq;
        logic [WORD_W-1:0] den;
        logic              q_neg;
        logic              r_neg;
        logic              zero;
    } idru_stage_t;

endpackage

`default_nettype wire

>>> rtl/core/idru_prep.sv
// Operand stage: takes magnitudes and sign flags, loads the head of the divide chain.
`default_nettype none

module idru_prep (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic                        func,
    input  wire logic [idru_pkg::WORD_W-1:0] dividend,
    input  wire logic [idru_pkg::WORD_W-1:0] divisor,
    output logic                             valid,
    output idru_pkg::idru_stage_t            stage
);
    import idru_pkg::*;

    logic        valid_reg;
    idru_stage_t stage_reg;
    idru_stage_t stage_next;
    logic        n_neg;
    logic        d_neg;

    always_comb
    begin
        n_neg = func & dividend[WORD_W-1];
        d_neg = func & divisor[WORD_W-1];
        stage_next.part  = '0;
        stage_next.nq    = n_neg ? (~dividend + 1'b1) : dividend;
        stage_next.den   = d_neg ? (~divisor + 1'b1) : divisor;
        stage_next.q_neg = n_neg ^ d_neg;
        stage_next.r_neg = n_neg;
        stage_next.zero  = (divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid = valid_reg;
    assign stage = stage_reg;

endmodule

`default_nettype wire

>>> rtl/core/idru_cell.sv
// One restoring shift-subtract step of the divide chain, registered.
`default_nettype none

module idru_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire idru_pkg::idru_stage_t in_stage,
    output logic                       out_valid,
    output idru_pkg::idru_stage_t      out_stage
);
    import idru_pkg::*;

    logic              valid_reg;
    idru_stage_t       stage_reg;
    idru_stage_t       stage_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;
    logic              fits;

    always_comb
    begin
        // Bring down the next dividend bit, then try the subtract.
        trial = {in_stage.part, in_stage.nq[WORD_W-1]};
        diff  = trial - {1'b0, in_stage.den};
        fits  = ~diff[WORD_W];
        stage_next       = in_stage;
        stage_next.part  = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        stage_next.nq    = {in_stage.nq[WORD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            stage_reg <= stage_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

`default_nettype wire

>>> rtl/core/idru_fix.sv
// Result stage: applies signs, clears zero-divisor results, drives the strobe.
`default_nettype none

module idru_fix (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire idru_pkg::idru_stage_t       in_stage,
    output logic                             done,
    output logic [idru_pkg::WORD_W-1:0]      quotient,
    output logic [idru_pkg::WORD_W-1:0]      remainder
);
    import idru_pkg::*;

    logic              done_reg;
    logic [WORD_W-1:0] quotient_reg;
    logic [WORD_W-1:0] remainder_reg;
    logic [WORD_W-1:0] quotient_next;
    logic [WORD_W-1:0] remainder_next;

    always_comb
    begin
        quotient_next  = in_stage.q_neg ? (~in_stage.nq + 1'b1) : in_stage.nq;
        remainder_next = in_stage.r_neg ? (~in_stage.part + 1'b1) : in_stage.part;
        if (in_stage.zero)
        begin
            quotient_next  = '0;
            remainder_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            quotient_reg  <= quotient_next;
            remainder_reg <= remainder_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

endmodule

`default_nettype wire

>>> rtl/core/int32_divide_remainder_unit.sv
// Pipelined 32-bit signed/unsigned divider: operand stage, 32 step cells, result stage.
// done pulses once an accepted item has passed the operand, cell and result registers in turn.
// Throughput: one item per cycle; busy stays low, each of the 32 cells does one step per item.
// Reset: rst_n clears all valid flags at once; results in flight are dropped.
// The receiver cannot stall: each result shows for the single cycle that done is high.
`default_nettype none

module int32_divide_remainder_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        func,
    input  wire logic [idru_pkg::WORD_W-1:0] dividend,
    input  wire logic [idru_pkg::WORD_W-1:0] divisor,
    output logic                             done,
    output logic [idru_pkg::WORD_W-1:0]      quotient,
    output logic [idru_pkg::WORD_W-1:0]      remainder
);
    import idru_pkg::*;

    logic        chain_valid [WORD_W+1];
    idru_stage_t chain_stage [WORD_W+1];
    logic        load;

    // Every stage advances every cycle, so a new item is always welcome.
    assign busy = 1'b0;
    assign load = start & ~busy;

    idru_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .func     (func),
        .dividend (dividend),
        .divisor  (divisor),
        .valid    (chain_valid[0]),
        .stage    (chain_stage[0])
    );

    for (genvar i = 0; i < WORD_W; i++)
    begin : g_cell
        idru_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_stage  (chain_stage[i]),
            .out_valid (chain_valid[i+1]),
            .out_stage (chain_stage[i+1])
        );
    end

    idru_fix u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[WORD_W]),
        .in_stage  (chain_stage[WORD_W]),
        .done      (done),
        .quotient  (quotient),
        .remainder (remainder)
    );

endmodule

`default_nettype wire

>>> rtl/core/idru_check.sv
// Port-level checks for the divide unit, bound to the top level.
`default_nettype none

module idru_check (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        func,
    input wire logic [idru_pkg::WORD_W-1:0] dividend,
    input wire logic [idru_pkg::WORD_W-1:0] divisor,
    input wire logic                        done,
    input wire logic [idru_pkg::WORD_W-1:0] quotient,
    input wire logic [idru_pkg::WORD_W-1:0] remainder
);
    import idru_pkg::*;

    localparam int LAT = 34;

    logic take;
    assign take = start & ~busy;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##LAT done)
        else $error("accepted item gave no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(take, LAT))
        else $error("result without accepted item");

    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        (take && divisor == '0) |-> ##LAT (quotient == '0 && remainder == '0))
        else $error("zero divisor result not cleared");

    a_unit_div: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !func && divisor == WORD_W'(1))
            |-> ##LAT (quotient == $past(dividend, LAT) && remainder == '0))
        else $error("unsigned divide by one wrong");

endmodule

bind int32_divide_remainder_unit idru_check u_check (.*);

`default_nettype wire
